/* hw/rtl/kvbt_pkg.sv */
// shared types and codes for the paged kv cache block table
package kvbt_pkg;

  localparam int OPW   = 3;
  localparam int LAYW  = 6;
  localparam int BLKW  = 10;
  localparam int STW   = 4;
  localparam int OFFW  = 8;
  localparam int HEADW = 6;
  localparam int ADDRW = 34;
  localparam int TOKW  = 13;
  localparam int CIDXW = 3;
  localparam int CDATW = 13;
  localparam int TPBW  = 9;
  localparam int CNTW  = 7;
  localparam int RWW   = 9;

  localparam logic [OPW-1:0] OP_BEGIN  = 3'd0;
  localparam logic [OPW-1:0] OP_APPEND = 3'd1;
  localparam logic [OPW-1:0] OP_COMMIT = 3'd2;
  localparam logic [OPW-1:0] OP_ABORT  = 3'd3;
  localparam logic [OPW-1:0] OP_RESET  = 3'd4;

  localparam logic [STW-1:0] ST_OK         = 4'd0;
  localparam logic [STW-1:0] ST_ACTIVE     = 4'd1;
  localparam logic [STW-1:0] ST_FULL       = 4'd2;
  localparam logic [STW-1:0] ST_NO_BLOCK   = 4'd3;
  localparam logic [STW-1:0] ST_UNCOVERED  = 4'd4;
  localparam logic [STW-1:0] ST_INACTIVE   = 4'd5;
  localparam logic [STW-1:0] ST_BAD_LAYER  = 4'd6;
  localparam logic [STW-1:0] ST_REPEAT     = 4'd7;
  localparam logic [STW-1:0] ST_INCOMPLETE = 4'd8;

  localparam logic [CIDXW-1:0] CFG_FIXED    = 3'd0;
  localparam logic [CIDXW-1:0] CFG_TPB      = 3'd1;
  localparam logic [CIDXW-1:0] CFG_CAPACITY = 3'd2;
  localparam logic [CIDXW-1:0] CFG_LAYERS   = 3'd3;
  localparam logic [CIDXW-1:0] CFG_HEADS    = 3'd4;
  localparam logic [CIDXW-1:0] CFG_ROW      = 3'd5;

  localparam logic [TOKW-1:0] TOK_SAT = 13'd8191;

  typedef struct packed {
    logic            start;
    logic [TOKW-1:0] dividend;
    logic [TPBW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [TOKW-1:0] quo;
    logic [OFFW-1:0] rem;
  } div_rsp_t;

endpackage

/* hw/rtl/kvbt_div.sv */
// restoring divider, one quotient bit per cycle, for token slot lookup
module kvbt_div (
  input  logic              clk,
  input  logic              rst,
  input  kvbt_pkg::div_req_t req,
  output kvbt_pkg::div_rsp_t rsp
);
  import kvbt_pkg::*;

  logic            busy;
  logic            done;
  logic [3:0]      cnt;
  logic [TPBW-1:0] rem;
  logic [TOKW-1:0] quo;
  logic [TPBW-1:0] dvs;
  logic [TPBW:0]   trial;
  logic            ge;

  assign trial = {rem, quo[TOKW-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == 4'(TOKW - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= ge ? TPBW'(trial - {1'b0, dvs}) : trial[TPBW-1:0];
        quo <= {quo[TOKW-2:0], ge};
        cnt <= cnt + 4'd1;
        if (cnt == 4'(TOKW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp = '{done: done, quo: quo, rem: rem[OFFW-1:0]};

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    !(req.start && busy))
    else $error("divider restarted while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while still busy");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dvs))
    else $error("remainder not below divisor");

endmodule

/* hw/rtl/kvbt_table.sv */
// block table memory, one write and one registered read port
module kvbt_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [kvbt_pkg::BLKW-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [kvbt_pkg::BLKW-1:0] rdata
);
  import kvbt_pkg::*;

  logic [BLKW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/paged_kv_cache_block_table.sv */
// channel  | signals                                        | dir
// in       | in_valid in_ready opcode layer granted_block   | in
//          | grant_valid                                    |
// out      | out_valid out_ready status block_taken ...last | out
// cfg      | cfg_write cfg_index cfg_data                   | in
// begin: divide, then one decision state and one result beat
// append: divide, table read (multi-page only), three multiply stages, then
// one head per cycle unless stalled; row addresses step by one add per head
// reset: one table read per released page, one release beat per cycle
// rst clears control state; the table holds no reset value and needs no sweep
// a stalled output holds the sequencer; one item is at work at a time
module paged_kv_cache_block_table #(
  parameter int MAX_PAGES   = 64,
  parameter int MAX_LAYERS  = 64,
  parameter int MAX_HEADS   = 64,
  parameter int MAX_BLOCKS  = 1024,
  parameter int MAX_CONTEXT = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [kvbt_pkg::CIDXW-1:0] cfg_index,
  input  logic [kvbt_pkg::CDATW-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [kvbt_pkg::OPW-1:0]   opcode,
  input  logic [kvbt_pkg::LAYW-1:0]  layer,
  input  logic [kvbt_pkg::BLKW-1:0]  granted_block,
  input  logic                       grant_valid,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kvbt_pkg::STW-1:0]   status,
  output logic                       block_taken,
  output logic [kvbt_pkg::BLKW-1:0]  phys_block,
  output logic [kvbt_pkg::OFFW-1:0]  slot_offset,
  output logic [kvbt_pkg::HEADW-1:0] head_index,
  output logic [kvbt_pkg::ADDRW-1:0] row_address,
  output logic [kvbt_pkg::TOKW-1:0]  attend_length,
  output logic [kvbt_pkg::BLKW-1:0]  released_block,
  output logic                       release_valid,
  output logic                       last
);
  import kvbt_pkg::*;

  localparam int AW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PW  = $clog2(MAX_PAGES + 1);
  localparam int LD  = (MAX_LAYERS < 64) ? MAX_LAYERS : 64;
  localparam int LDW = (LD > 1) ? $clog2(LD) : 1;
  localparam int CW  = 18;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DEC, S_RD, S_MUL1, S_MUL2, S_MUL3, S_HEAD, S_ONE, S_REL
  } state_t;

  typedef enum logic [1:0] {ACT_NONE, ACT_BEGIN, ACT_COMMIT, ACT_CLEAR} act_t;

  // configuration
  logic             single_page;
  logic [TPBW-1:0]  tokens_per_block;
  logic [TOKW-1:0]  context_capacity;
  logic [CNTW-1:0]  layers_in_use;
  logic [CNTW-1:0]  heads_in_use;
  logic [RWW-1:0]   row_width;

  // transaction state
  logic [PW-1:0]    pages_held;
  logic [TOKW-1:0]  token_count;
  logic             in_tx;
  logic             page_pending;
  logic [LD-1:0]    layers_done;

  state_t           state;
  act_t             act;
  logic [OPW-1:0]   op;
  logic [LAYW-1:0]  lay;
  logic [BLKW-1:0]  gblk;
  logic             gval;
  logic [STW-1:0]   res_status;
  logic             res_taken;
  logic [TOKW-1:0]  logical;
  logic [OFFW-1:0]  offset;
  logic [BLKW-1:0]  pblk;
  logic [16:0]      prod1;
  logic [26:0]      prod2;
  logic [17:0]      step;
  logic [ADDRW-1:0] addr;
  logic [HEADW-1:0] head;
  logic [AW-1:0]    rel_idx;
  logic [PW-1:0]    rel_first;

  div_req_t         dreq;
  div_rsp_t         drsp;

  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [BLKW-1:0]  mem_rdata;

  // effective configuration
  logic [TPBW-1:0]  tpb_eff;
  logic [CNTW-1:0]  heads_eff;
  logic [CW-1:0]    layers_eff;
  logic [CW-1:0]    cap_eff;

  always_comb begin
    tpb_eff = tokens_per_block;
    if (tokens_per_block == '0) tpb_eff = TPBW'(1);
    if (tokens_per_block > TPBW'(256)) tpb_eff = TPBW'(256);
    heads_eff = heads_in_use;
    if (heads_in_use == '0) heads_eff = CNTW'(1);
    if (CW'(heads_in_use) > CW'(MAX_HEADS)) heads_eff = CNTW'(MAX_HEADS);
    layers_eff = CW'(layers_in_use);
    if (layers_eff > CW'(MAX_LAYERS)) layers_eff = CW'(MAX_LAYERS);
    cap_eff = CW'(context_capacity);
    if (cap_eff > CW'(MAX_CONTEXT)) cap_eff = CW'(MAX_CONTEXT);
  end

  logic can_push;
  logic beat_push;
  assign can_push  = !out_valid || out_ready;
  assign beat_push = can_push && (state == S_HEAD || state == S_ONE || state == S_REL);
  assign in_ready  = (state == S_IDLE);

  // decision helpers, meaningful in S_DEC
  logic [CW-1:0] q_ext;
  logic [CW-1:0] ph_ext;
  logic [LD-1:0] need_mask;
  logic          all_done;
  logic          rel_abort;
  logic          rel_any;
  logic [PW-1:0] reset_first;
  logic          pend_rel;
  logic [PW-1:0] rel_start;

  assign q_ext    = CW'(logical);
  assign ph_ext   = CW'(pages_held);
  assign pend_rel = in_tx && page_pending && (pages_held != '0);

  always_comb begin
    for (int i = 0; i < LD; i++) begin
      need_mask[i] = CW'(i) < layers_eff;
    end
  end

  assign all_done    = (layers_eff <= CW'(LD)) && (&(layers_done | ~need_mask));
  assign rel_abort   = pend_rel;
  assign rel_any     = single_page ? pend_rel : (pages_held != '0);
  assign reset_first = (single_page && pend_rel) ? PW'(pages_held - PW'(1)) :
                       (single_page ? pages_held : '0);
  assign rel_start   = (op == OP_ABORT) ? PW'(pages_held - PW'(1)) : reset_first;

  logic app_table;
  logic rel_last;
  logic abort_done;
  assign app_table = (op == OP_APPEND) && in_tx && (CW'(lay) < layers_eff) &&
                     !layers_done[lay[LDW-1:0]] && !single_page &&
                     (q_ext < ph_ext) && (q_ext < CW'(MAX_PAGES));
  assign rel_last  = (CW'(rel_idx) == CW'(PW'(pages_held - PW'(1))));
  assign abort_done = (op == OP_ABORT);

  // event decision
  logic [STW-1:0] dec_status;
  logic           dec_taken;
  act_t           dec_act;
  state_t         dec_state;

  always_comb begin
    dec_status = ST_OK;
    dec_taken  = 1'b0;
    dec_act    = ACT_NONE;
    dec_state  = S_ONE;
    case (op)
      OP_BEGIN: begin
        if (in_tx) dec_status = ST_ACTIVE;
        else if (CW'(token_count) >= cap_eff) dec_status = ST_FULL;
        else if (single_page) begin
          if (logical != '0) dec_status = ST_UNCOVERED;
          else dec_act = ACT_BEGIN;
        end else if (q_ext == ph_ext) begin
          if (ph_ext >= CW'(MAX_PAGES)) dec_status = ST_FULL;
          else if (!gval || CW'(gblk) >= CW'(MAX_BLOCKS))
            dec_status = ST_NO_BLOCK;
          else begin
            dec_taken = 1'b1;
            dec_act   = ACT_BEGIN;
          end
        end else if (q_ext > ph_ext) dec_status = ST_UNCOVERED;
        else dec_act = ACT_BEGIN;
      end
      OP_APPEND: begin
        if (!in_tx) dec_status = ST_INACTIVE;
        else if (CW'(lay) >= layers_eff) dec_status = ST_BAD_LAYER;
        else if (layers_done[lay[LDW-1:0]]) dec_status = ST_REPEAT;
        else if (single_page) begin
          if (logical != '0) dec_status = ST_UNCOVERED;
          else dec_state = S_MUL1;
        end else if (app_table) dec_state = S_RD;
        else dec_status = ST_UNCOVERED;
      end
      OP_COMMIT: begin
        if (!in_tx) dec_status = ST_INACTIVE;
        else if (!all_done) dec_status = ST_INCOMPLETE;
        else dec_act = ACT_COMMIT;
      end
      OP_ABORT: begin
        if (in_tx) begin
          if (rel_abort) dec_state = S_REL;
          else dec_act = ACT_CLEAR;
        end
      end
      OP_RESET: begin
        if (rel_any) dec_state = S_REL;
        else dec_act = ACT_CLEAR;
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (state == S_DEC) begin
      if (app_table) begin
        mem_re    = 1'b1;
        mem_raddr = AW'(logical);
      end else if (op == OP_ABORT && rel_abort) begin
        mem_re    = 1'b1;
        mem_raddr = AW'(pages_held - PW'(1));
      end else if (op == OP_RESET && rel_any) begin
        mem_re    = 1'b1;
        mem_raddr = AW'(reset_first);
      end
    end else if (state == S_REL && can_push && !rel_last) begin
      mem_re    = 1'b1;
      mem_raddr = AW'(rel_idx + AW'(1));
    end
  end

  assign mem_we = (state == S_ONE) && can_push && (act == ACT_BEGIN) && res_taken;

  assign dreq.start    = in_valid && in_ready &&
                         (opcode == OP_BEGIN || opcode == OP_APPEND);
  assign dreq.dividend = token_count;
  assign dreq.divisor  = tpb_eff;

  kvbt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  kvbt_table #(
    .DEPTH (MAX_PAGES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(pages_held)),
    .wdata (gblk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      single_page      <= 1'b0;
      tokens_per_block <= TPBW'(16);
      context_capacity <= TOKW'(4096);
      layers_in_use    <= CNTW'(32);
      heads_in_use     <= CNTW'(32);
      row_width        <= RWW'(128);
      pages_held       <= '0;
      token_count      <= '0;
      in_tx            <= 1'b0;
      page_pending     <= 1'b0;
      layers_done      <= '0;
      state            <= S_IDLE;
      act              <= ACT_NONE;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_FIXED:    single_page      <= cfg_data[0];
          CFG_TPB:      tokens_per_block <= cfg_data[TPBW-1:0];
          CFG_CAPACITY: context_capacity <= cfg_data;
          CFG_LAYERS:   layers_in_use    <= cfg_data[CNTW-1:0];
          CFG_HEADS:    heads_in_use     <= cfg_data[CNTW-1:0];
          CFG_ROW:      row_width        <= cfg_data[RWW-1:0];
          default: ;
        endcase
      end

      if (beat_push) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= opcode;
            lay   <= layer;
            gblk  <= granted_block;
            gval  <= grant_valid;
            state <= dreq.start ? S_DIV : S_DEC;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            logical <= drsp.quo;
            offset  <= drsp.rem;
            state   <= S_DEC;
          end
        end
        S_DEC: begin
          res_status <= dec_status;
          res_taken  <= dec_taken;
          act        <= dec_act;
          pblk       <= '0;
          rel_idx    <= AW'(rel_start);
          rel_first  <= rel_start;
          state      <= dec_state;
        end
        S_RD: begin
          pblk  <= mem_rdata;
          state <= S_MUL1;
        end
        S_MUL1: begin
          prod1 <= 17'(pblk) * 17'(heads_eff);
          step  <= 18'(tpb_eff) * 18'(row_width);
          state <= S_MUL2;
        end
        S_MUL2: begin
          prod2 <= 27'(prod1) * 27'(tpb_eff) + 27'(offset);
          state <= S_MUL3;
        end
        S_MUL3: begin
          addr  <= ADDRW'(prod2) * ADDRW'(row_width);
          head  <= '0;
          state <= S_HEAD;
        end
        S_HEAD: begin
          if (can_push) begin
            status         <= ST_OK;
            block_taken    <= 1'b0;
            phys_block     <= pblk;
            slot_offset    <= offset;
            head_index     <= head;
            row_address    <= addr;
            attend_length  <= token_count + TOKW'(1);
            released_block <= '0;
            release_valid  <= 1'b0;
            last           <= (CNTW'(head) == CNTW'(heads_eff - CNTW'(1)));
            addr           <= addr + ADDRW'(step);
            head           <= head + HEADW'(1);
            if (CNTW'(head) == CNTW'(heads_eff - CNTW'(1))) begin
              layers_done[lay[LDW-1:0]] <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_ONE: begin
          if (can_push) begin
            status         <= res_status;
            block_taken    <= res_taken;
            phys_block     <= '0;
            slot_offset    <= '0;
            head_index     <= '0;
            row_address    <= '0;
            attend_length  <= '0;
            released_block <= '0;
            release_valid  <= 1'b0;
            last           <= 1'b1;
            state          <= S_IDLE;
            case (act)
              ACT_BEGIN: begin
                if (res_taken) begin
                  pages_held   <= pages_held + PW'(1);
                  page_pending <= 1'b1;
                end
                layers_done <= '0;
                in_tx       <= 1'b1;
              end
              ACT_COMMIT: begin
                if (token_count != TOK_SAT) token_count <= token_count + TOKW'(1);
                in_tx        <= 1'b0;
                page_pending <= 1'b0;
              end
              ACT_CLEAR: begin
                layers_done  <= '0;
                in_tx        <= 1'b0;
                page_pending <= 1'b0;
                if (op == OP_RESET) token_count <= '0;
              end
              default: ;
            endcase
          end
        end
        S_REL: begin
          if (can_push) begin
            status         <= ST_OK;
            block_taken    <= 1'b0;
            phys_block     <= '0;
            slot_offset    <= '0;
            head_index     <= '0;
            row_address    <= '0;
            attend_length  <= '0;
            released_block <= mem_rdata;
            release_valid  <= 1'b1;
            last           <= rel_last;
            rel_idx        <= rel_idx + AW'(1);
            if (rel_last) begin
              pages_held   <= rel_first;
              layers_done  <= '0;
              in_tx        <= 1'b0;
              page_pending <= 1'b0;
              if (!abort_done) token_count <= '0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pages_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(pages_held) <= CW'(MAX_PAGES))
    else $error("pages_held beyond table depth");

  a_pending_in_tx: assert property (@(posedge clk) disable iff (rst)
    page_pending |-> in_tx)
    else $error("pending page outside a transaction");

  a_taken_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && block_taken) |-> page_pending)
    else $error("block taken beat without a pending page");

  a_release_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && release_valid) |-> (status == ST_OK && !block_taken))
    else $error("release beat with bad status");

endmodule
